[rtl/core/sst_pkg.sv]
`timescale 1ns / 1ps

package sst_pkg;

  localparam int OPCODE_W    = 3;
  localparam int LEN_IN_W    = 16;
  localparam int CODE_W      = 16;
  localparam int OUT_LEN_W   = 4;
  localparam int OUT_COUNT_W = 6;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT      = 3'd0,
    OP_TEXT_DELETE = 3'd1,
    OP_TEXT_INSERT = 3'd2,
    OP_LOOKUP      = 3'd3,
    OP_CANCEL_MARK = 3'd4,
    OP_SET_MARK    = 3'd5,
    OP_STATUS      = 3'd6
  } opcode_e;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_EVAL,
    CMD_INSERT,
    CMD_SHIFT
  } cell_cmd_e;

  // Prefix flags that ripple from cell 0 toward the tail of the chain.
  typedef struct packed {
    logic ins_seen;
    logic kill_seen;
    logic hit_seen;
  } chain_t;

endpackage

[rtl/core/sst_in_if.sv]
`timescale 1ns / 1ps

interface sst_in_if #(
  parameter int POS_BITS = 16
);
  logic                                valid;
  logic                                ready;
  logic [sst_pkg::OPCODE_W-1:0]        opcode;
  logic [POS_BITS-1:0]                 position;
  logic [sst_pkg::LEN_IN_W-1:0]        length;
  logic [sst_pkg::CODE_W-1:0]          symbol_code;

  modport source (output valid, output opcode, output position, output length,
                  output symbol_code, input ready);
  modport sink (input valid, input opcode, input position, input length,
                input symbol_code, output ready);
endinterface

[rtl/core/sst_out_if.sv]
`timescale 1ns / 1ps

interface sst_out_if #(
  parameter int POS_BITS = 16
);
  logic                                valid;
  logic                                ready;
  logic                                hit;
  logic [POS_BITS-1:0]                 span_start;
  logic [sst_pkg::OUT_LEN_W-1:0]       span_length;
  logic [sst_pkg::CODE_W-1:0]          span_code;
  logic                                span_marked;
  logic [sst_pkg::OUT_COUNT_W-1:0]     span_count;
  logic                                dropped;

  modport source (output valid, output hit, output span_start, output span_length,
                  output span_code, output span_marked, output span_count,
                  output dropped, input ready);
  modport sink (input valid, input hit, input span_start, input span_length,
                input span_code, input span_marked, input span_count,
                input dropped, output ready);
endinterface

[rtl/core/sst_cell.sv]
`timescale 1ns / 1ps

module sst_cell #(
  parameter int POS_BITS     = 16,
  parameter int LEN_W        = 4,
  parameter int MAX_SPAN_LEN = 15
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sst_pkg::cell_cmd_e            cmd_i,
  input  sst_pkg::opcode_e              opcode_i,
  input  logic [POS_BITS-1:0]           position_i,
  input  logic [sst_pkg::LEN_IN_W-1:0]  length_i,
  input  logic [sst_pkg::CODE_W-1:0]    code_i,
  input  logic                          valid_i,
  input  sst_pkg::chain_t               chain_i,
  output sst_pkg::chain_t               chain_o,
  input  logic [POS_BITS-1:0]           left_start_i,
  input  logic [LEN_W-1:0]              left_len_i,
  input  logic [sst_pkg::CODE_W-1:0]    left_code_i,
  input  logic                          left_mark_i,
  input  logic [POS_BITS-1:0]           right_start_i,
  input  logic [LEN_W-1:0]              right_len_i,
  input  logic [sst_pkg::CODE_W-1:0]    right_code_i,
  input  logic                          right_mark_i,
  input  logic                          right_kill_i,
  output logic [POS_BITS-1:0]           start_o,
  output logic [LEN_W-1:0]              len_o,
  output logic [sst_pkg::CODE_W-1:0]    code_o,
  output logic                          mark_o,
  output logic                          kill_o,
  output logic                          sel_o
);

  localparam int SUM_W = ((POS_BITS > sst_pkg::LEN_IN_W) ? POS_BITS : sst_pkg::LEN_IN_W) + 1;

  logic [POS_BITS-1:0]        start_q;
  logic [LEN_W-1:0]           len_q;
  logic [sst_pkg::CODE_W-1:0] code_q;
  logic                       mark_q;
  logic                       kill_q;
  logic                       hit_q;

  logic [SUM_W-1:0] s_w, e_w, p_w, l_w, pe_w, sum_w, diff_w, max_w;
  logic             overlap, covers, at_or_after, ins_here, kill_take;
  logic [POS_BITS-1:0] grown_start, shrunk_start;
  logic [LEN_W-1:0]    new_len;

  always_comb begin
    s_w          = SUM_W'(start_q);
    e_w          = s_w + SUM_W'(len_q);
    p_w          = SUM_W'(position_i);
    l_w          = SUM_W'(length_i);
    pe_w         = p_w + l_w;
    sum_w        = s_w + l_w;
    diff_w       = s_w - l_w;
    max_w        = SUM_W'({POS_BITS{1'b1}});
    overlap      = (s_w < pe_w) && (e_w > p_w);
    covers       = (s_w <= p_w) && (e_w > p_w);
    at_or_after  = s_w >= p_w;
    grown_start  = (sum_w > max_w) ? {POS_BITS{1'b1}} : sum_w[POS_BITS-1:0];
    shrunk_start = (s_w >= l_w) ? diff_w[POS_BITS-1:0] : '0;
    new_len      = (length_i > sst_pkg::LEN_IN_W'(MAX_SPAN_LEN)) ?
                   LEN_W'(MAX_SPAN_LEN) : LEN_W'(length_i);
    ins_here     = !valid_i || at_or_after;
    kill_take    = chain_i.kill_seen || kill_q;
  end

  assign chain_o.ins_seen  = chain_i.ins_seen || ins_here;
  assign chain_o.kill_seen = kill_take;
  assign chain_o.hit_seen  = chain_i.hit_seen || hit_q;

  assign start_o = start_q;
  assign len_o   = len_q;
  assign code_o  = code_q;
  assign mark_o  = mark_q;
  assign kill_o  = kill_q;
  assign sel_o   = hit_q && !chain_i.hit_seen;

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      sst_pkg::CMD_INSERT: begin
        if (chain_i.ins_seen) begin
          start_q <= left_start_i;
          len_q   <= left_len_i;
          code_q  <= left_code_i;
          mark_q  <= left_mark_i;
        end else if (ins_here) begin
          start_q <= position_i;
          len_q   <= new_len;
          code_q  <= code_i;
          mark_q  <= 1'b0;
        end
      end
      sst_pkg::CMD_EVAL: begin
        case (opcode_i)
          sst_pkg::OP_TEXT_DELETE: begin
            if (at_or_after) start_q <= shrunk_start;
          end
          sst_pkg::OP_TEXT_INSERT: begin
            if (at_or_after) start_q <= grown_start;
          end
          sst_pkg::OP_CANCEL_MARK: begin
            mark_q <= 1'b0;
          end
          sst_pkg::OP_SET_MARK: begin
            if (valid_i && overlap) mark_q <= 1'b1;
          end
          default: begin
          end
        endcase
      end
      sst_pkg::CMD_SHIFT: begin
        if (kill_take) begin
          start_q <= right_start_i;
          len_q   <= right_len_i;
          code_q  <= right_code_i;
          mark_q  <= right_mark_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kill_q <= 1'b0;
      hit_q  <= 1'b0;
    end else begin
      case (cmd_i)
        sst_pkg::CMD_EVAL: begin
          kill_q <= (opcode_i == sst_pkg::OP_TEXT_DELETE) && valid_i && overlap;
          hit_q  <= (opcode_i == sst_pkg::OP_LOOKUP) && valid_i && covers;
        end
        sst_pkg::CMD_SHIFT: begin
          if (kill_take) kill_q <= right_kill_i;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/core/sorted_span_table.sv]
`timescale 1ns / 1ps

// Sorted span table built as a chain of TABLE_DEPTH cells, one span per cell.
// A word is taken only while the controller is idle; the result can still be
// waiting in the output register at that time. Each word passes the idle
// state that accepts it, an execute state in which every cell acts at once,
// and a response state that forms the result once the output register is
// free. A text delete runs compaction between the two until no removed
// span is left; the chain closes up one gap per cycle by moving every entry
// behind the first removed one a cell toward the head.

module sorted_span_table #(
  parameter int TABLE_DEPTH  = 32,
  parameter int MAX_SPAN_LEN = 15,
  parameter int POS_BITS     = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sst_in_if.sink     in_i,
  sst_out_if.source  out_o
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int LEN_W = $clog2(MAX_SPAN_LEN + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_COMPACT,
    ST_RESP
  } state_e;

  state_e                      state_q;
  logic [CNT_W-1:0]            count_q;
  sst_pkg::opcode_e            op_q;
  logic [POS_BITS-1:0]         pos_q;
  logic [sst_pkg::LEN_IN_W-1:0] len_q;
  logic [sst_pkg::CODE_W-1:0]  code_q;
  logic                        drop_q;

  logic                        out_valid_q;
  logic                        out_hit_q;
  logic [POS_BITS-1:0]         out_start_q;
  logic [sst_pkg::OUT_LEN_W-1:0] out_len_q;
  logic [sst_pkg::CODE_W-1:0]  out_code_q;
  logic                        out_mark_q;
  logic [sst_pkg::OUT_COUNT_W-1:0] out_count_q;
  logic                        out_drop_q;

  sst_pkg::cell_cmd_e          cmd;
  logic                        full, any_kill, any_hit, is_lookup, out_free;

  sst_pkg::chain_t             chain  [TABLE_DEPTH+1];
  logic [POS_BITS-1:0]         cell_start [TABLE_DEPTH];
  logic [LEN_W-1:0]            cell_len   [TABLE_DEPTH];
  logic [sst_pkg::CODE_W-1:0]  cell_code  [TABLE_DEPTH];
  logic                        cell_mark  [TABLE_DEPTH];
  logic                        cell_kill  [TABLE_DEPTH];
  logic                        cell_sel   [TABLE_DEPTH];

  logic [POS_BITS-1:0]         found_start;
  logic [LEN_W-1:0]            found_len;
  logic [sst_pkg::CODE_W-1:0]  found_code;
  logic                        found_mark;

  assign chain[0]  = '0;
  assign full      = count_q == CNT_W'(TABLE_DEPTH);
  assign any_kill  = chain[TABLE_DEPTH].kill_seen;
  assign any_hit   = chain[TABLE_DEPTH].hit_seen;
  assign is_lookup = op_q == sst_pkg::OP_LOOKUP;
  assign out_free  = !out_valid_q || out_o.ready;

  assign in_i.ready = state_q == ST_IDLE;

  always_comb begin
    case (state_q)
      ST_EXEC: begin
        if (op_q == sst_pkg::OP_INSERT) begin
          cmd = full ? sst_pkg::CMD_HOLD : sst_pkg::CMD_INSERT;
        end else begin
          cmd = sst_pkg::CMD_EVAL;
        end
      end
      ST_COMPACT: cmd = sst_pkg::CMD_SHIFT;
      default:    cmd = sst_pkg::CMD_HOLD;
    endcase
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [POS_BITS-1:0]        l_start, r_start;
    logic [LEN_W-1:0]           l_len, r_len;
    logic [sst_pkg::CODE_W-1:0] l_code, r_code;
    logic                       l_mark, r_mark, r_kill, valid;

    assign valid = CNT_W'(i) < count_q;

    if (i == 0) begin : g_head
      assign l_start = '0;
      assign l_len   = '0;
      assign l_code  = '0;
      assign l_mark  = 1'b0;
    end else begin : g_body
      assign l_start = cell_start[i-1];
      assign l_len   = cell_len[i-1];
      assign l_code  = cell_code[i-1];
      assign l_mark  = cell_mark[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign r_start = '0;
      assign r_len   = '0;
      assign r_code  = '0;
      assign r_mark  = 1'b0;
      assign r_kill  = 1'b0;
    end else begin : g_inner
      assign r_start = cell_start[i+1];
      assign r_len   = cell_len[i+1];
      assign r_code  = cell_code[i+1];
      assign r_mark  = cell_mark[i+1];
      assign r_kill  = cell_kill[i+1];
    end

    sst_cell #(
      .POS_BITS     (POS_BITS),
      .LEN_W        (LEN_W),
      .MAX_SPAN_LEN (MAX_SPAN_LEN)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .opcode_i      (op_q),
      .position_i    (pos_q),
      .length_i      (len_q),
      .code_i        (code_q),
      .valid_i       (valid),
      .chain_i       (chain[i]),
      .chain_o       (chain[i+1]),
      .left_start_i  (l_start),
      .left_len_i    (l_len),
      .left_code_i   (l_code),
      .left_mark_i   (l_mark),
      .right_start_i (r_start),
      .right_len_i   (r_len),
      .right_code_i  (r_code),
      .right_mark_i  (r_mark),
      .right_kill_i  (r_kill),
      .start_o       (cell_start[i]),
      .len_o         (cell_len[i]),
      .code_o        (cell_code[i]),
      .mark_o        (cell_mark[i]),
      .kill_o        (cell_kill[i]),
      .sel_o         (cell_sel[i])
    );
  end

  always_comb begin
    found_start = '0;
    found_len   = '0;
    found_code  = '0;
    found_mark  = 1'b0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (cell_sel[k]) begin
        found_start = found_start | cell_start[k];
        found_len   = found_len | cell_len[k];
        found_code  = found_code | cell_code[k];
        found_mark  = found_mark | cell_mark[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_drop_q  <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready && (state_q != ST_RESP)) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            op_q    <= sst_pkg::opcode_e'(in_i.opcode);
            pos_q   <= in_i.position;
            len_q   <= in_i.length;
            code_q  <= in_i.symbol_code;
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          drop_q <= (op_q == sst_pkg::OP_INSERT) && full;
          if ((op_q == sst_pkg::OP_INSERT) && !full) begin
            count_q <= count_q + CNT_W'(1);
          end
          state_q <= (op_q == sst_pkg::OP_TEXT_DELETE) ? ST_COMPACT : ST_RESP;
        end
        ST_COMPACT: begin
          if (any_kill) begin
            count_q <= count_q - CNT_W'(1);
          end else begin
            state_q <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_hit_q   <= is_lookup && any_hit;
            out_start_q <= is_lookup ? found_start : '0;
            out_len_q   <= is_lookup ? sst_pkg::OUT_LEN_W'(found_len) : '0;
            out_code_q  <= is_lookup ? found_code : '0;
            out_mark_q  <= is_lookup && found_mark;
            out_count_q <= sst_pkg::OUT_COUNT_W'(count_q);
            out_drop_q  <= drop_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.hit         = out_hit_q;
  assign out_o.span_start  = out_start_q;
  assign out_o.span_length = out_len_q;
  assign out_o.span_code   = out_code_q;
  assign out_o.span_marked = out_mark_q;
  assign out_o.span_count  = out_count_q;
  assign out_o.dropped     = out_drop_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("span count above table depth");

  a_compact_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMPACT) && any_kill |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("compaction step did not remove exactly one span");

  a_insert_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) && (op_q == sst_pkg::OP_INSERT) && !full
    |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("accepted insert did not grow the table");

  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_RESP)
    else $error("result word raised outside the response state");

endmodule

[tb/span_table_checker.sv]
`timescale 1ns / 1ps

// Watches both channels, keeps its own copy of the span table and compares
// every result word with the oldest expected one.
module span_table_checker #(
  parameter int TABLE_DEPTH  = 32,
  parameter int MAX_SPAN_LEN = 15,
  parameter int POS_BITS     = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  sst_in_if    edit_i,
  sst_out_if   result_i,
  output int   mismatch_count_o,
  output int   pending_o,
  output int   checked_o,
  output int   hits_o,
  output int   drops_o
);

  localparam int LEN_W = $clog2(MAX_SPAN_LEN + 1);
  localparam longint unsigned POS_MAX = (64'd1 << POS_BITS) - 1;

  typedef struct packed {
    logic                            hit;
    logic [POS_BITS-1:0]             span_start;
    logic [sst_pkg::OUT_LEN_W-1:0]   span_length;
    logic [sst_pkg::CODE_W-1:0]      span_code;
    logic                            span_marked;
    logic [sst_pkg::OUT_COUNT_W-1:0] span_count;
    logic                            dropped;
  } span_result_t;

  logic [POS_BITS-1:0]        start_tbl [TABLE_DEPTH];
  logic [LEN_W-1:0]           len_tbl   [TABLE_DEPTH];
  logic [sst_pkg::CODE_W-1:0] code_tbl  [TABLE_DEPTH];
  logic                       mark_tbl  [TABLE_DEPTH];
  int                         span_total;

  span_result_t awaited_results [$];
  int mismatches;
  int checked;
  int hits;
  int drops;

  function automatic bit span_overlaps(input int k, input longint unsigned lo,
                                       input longint unsigned n);
    longint unsigned s;
    s = 64'(start_tbl[k]);
    return (s < lo + n) && (s + 64'(len_tbl[k]) > lo);
  endfunction

  function automatic void move_entry(input int dst, input int src);
    start_tbl[dst] = start_tbl[src];
    len_tbl[dst]   = len_tbl[src];
    code_tbl[dst]  = code_tbl[src];
    mark_tbl[dst]  = mark_tbl[src];
  endfunction

  function automatic span_result_t apply_edit(input logic [sst_pkg::OPCODE_W-1:0] op,
                                              input logic [POS_BITS-1:0]          pos,
                                              input logic [sst_pkg::LEN_IN_W-1:0] len,
                                              input logic [sst_pkg::CODE_W-1:0]   code);
    span_result_t    res;
    int              at;
    int              k;
    int              wr;
    bit              found;
    longint unsigned moved;
    res = '0;
    case (op)
      sst_pkg::OP_INSERT: begin
        if (span_total >= TABLE_DEPTH) begin
          res.dropped = 1'b1;
        end else begin
          at = 0;
          while (at < span_total && start_tbl[at] < pos) at++;
          for (k = span_total; k > at; k--) move_entry(k, k - 1);
          start_tbl[at] = pos;
          len_tbl[at]   = (len > sst_pkg::LEN_IN_W'(MAX_SPAN_LEN)) ?
                          LEN_W'(MAX_SPAN_LEN) : LEN_W'(len);
          code_tbl[at]  = code;
          mark_tbl[at]  = 1'b0;
          span_total++;
        end
      end
      sst_pkg::OP_TEXT_DELETE: begin
        wr = 0;
        for (k = 0; k < span_total; k++) begin
          if (!span_overlaps(k, 64'(pos), 64'(len))) begin
            move_entry(wr, k);
            wr++;
          end
        end
        span_total = wr;
        for (k = 0; k < span_total; k++) begin
          if (start_tbl[k] >= pos) begin
            start_tbl[k] = (64'(start_tbl[k]) >= 64'(len)) ?
                           POS_BITS'(64'(start_tbl[k]) - 64'(len)) : '0;
          end
        end
      end
      sst_pkg::OP_TEXT_INSERT: begin
        for (k = 0; k < span_total; k++) begin
          if (start_tbl[k] >= pos) begin
            moved = 64'(start_tbl[k]) + 64'(len);
            start_tbl[k] = (moved > POS_MAX) ? POS_BITS'(POS_MAX) : POS_BITS'(moved);
          end
        end
      end
      sst_pkg::OP_LOOKUP: begin
        found = 1'b0;
        for (k = 0; k < span_total; k++) begin
          if (!found && start_tbl[k] <= pos &&
              64'(start_tbl[k]) + 64'(len_tbl[k]) > 64'(pos)) begin
            found           = 1'b1;
            res.hit         = 1'b1;
            res.span_start  = start_tbl[k];
            res.span_length = sst_pkg::OUT_LEN_W'(len_tbl[k]);
            res.span_code   = code_tbl[k];
            res.span_marked = mark_tbl[k];
          end
        end
      end
      sst_pkg::OP_CANCEL_MARK: begin
        for (k = 0; k < span_total; k++) mark_tbl[k] = 1'b0;
      end
      sst_pkg::OP_SET_MARK: begin
        for (k = 0; k < span_total; k++) begin
          if (span_overlaps(k, 64'(pos), 64'(len))) mark_tbl[k] = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.span_count = sst_pkg::OUT_COUNT_W'(span_total);
    return res;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    span_result_t want;
    span_result_t got;
    got = '{hit: result_i.hit, span_start: result_i.span_start,
            span_length: result_i.span_length, span_code: result_i.span_code,
            span_marked: result_i.span_marked, span_count: result_i.span_count,
            dropped: result_i.dropped};
    checked++;
    if (got.hit) hits++;
    if (got.dropped) drops++;
    if (awaited_results.size() == 0) begin
      $display("%0t ns: result word with nothing expected, actual %p", $time, got);
      mismatches++;
    end else begin
      want = awaited_results.pop_front();
      compare_field("hit", 32'(want.hit), 32'(got.hit));
      compare_field("span_start", 32'(want.span_start), 32'(got.span_start));
      compare_field("span_length", 32'(want.span_length), 32'(got.span_length));
      compare_field("span_code", 32'(want.span_code), 32'(got.span_code));
      compare_field("span_marked", 32'(want.span_marked), 32'(got.span_marked));
      compare_field("span_count", 32'(want.span_count), 32'(got.span_count));
      compare_field("dropped", 32'(want.dropped), 32'(got.dropped));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_total = 0;
      awaited_results.delete();
      mismatches = 0;
      checked    = 0;
      hits       = 0;
      drops      = 0;
    end else begin
      if (result_i.valid && result_i.ready) check_result();
      if (edit_i.valid && edit_i.ready) begin
        awaited_results.push_back(apply_edit(edit_i.opcode, edit_i.position,
                                             edit_i.length, edit_i.symbol_code));
      end
    end
    mismatch_count_o <= mismatches;
    pending_o        <= awaited_results.size();
    checked_o        <= checked;
    hits_o           <= hits;
    drops_o          <= drops;
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int TABLE_DEPTH     = 32;
  localparam int MAX_SPAN_LEN    = 15;
  localparam int POS_BITS        = 16;
  localparam int PHASES          = 8;
  localparam int WORDS_PER_PHASE = 50;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int DRAIN_CYCLES    = 48;

  localparam logic [sst_pkg::OPCODE_W-1:0] OP_UNUSED = 3'd7;

  logic clk_i;
  logic rst_ni;
  bit   steady_flow;
  bit   hold_off_req;
  int   words_sent;
  int   mismatch_count;
  int   pending;
  int   checked;
  int   hits;
  int   drops;

  sst_in_if  #(.POS_BITS(POS_BITS)) edit_if ();
  sst_out_if #(.POS_BITS(POS_BITS)) result_if ();

  sorted_span_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_SPAN_LEN(MAX_SPAN_LEN),
    .POS_BITS    (POS_BITS)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (edit_if),
    .out_o (result_if)
  );

  span_table_checker #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_SPAN_LEN(MAX_SPAN_LEN),
    .POS_BITS    (POS_BITS)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .edit_i          (edit_if),
    .result_i        (result_if),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending),
    .checked_o       (checked),
    .hits_o          (hits),
    .drops_o         (drops)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #500000;
    $display("Timed out waiting for the span table.");
    $display("Mismatches found");
    $finish;
  end

  // Outside the steady-flow phases the result side stalls at random, once for a
  // long stretch so that the table stops taking words.
  initial begin
    int stall;
    result_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = HOLD_OFF_CYCLES;
      end else if (steady_flow) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 7);
      end
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk_i); while (!result_if.valid);
    end
  end

  task automatic send_word(input logic [sst_pkg::OPCODE_W-1:0] op,
                           input logic [POS_BITS-1:0] pos,
                           input logic [sst_pkg::LEN_IN_W-1:0] len,
                           input logic [sst_pkg::CODE_W-1:0] code);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      edit_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    edit_if.valid       <= 1'b1;
    edit_if.opcode      <= op;
    edit_if.position    <= pos;
    edit_if.length      <= len;
    edit_if.symbol_code <= code;
    do @(posedge clk_i); while (!edit_if.ready);
    words_sent++;
  endtask

  task automatic send_random(input bit fill_table);
    logic [sst_pkg::OPCODE_W-1:0] op;
    logic [POS_BITS-1:0]          pos;
    logic [sst_pkg::LEN_IN_W-1:0] len;
    int                           pick;
    pick = $urandom_range(0, 99);
    if (fill_table) begin
      if (pick < 75) op = sst_pkg::OP_INSERT;
      else if (pick < 90) op = sst_pkg::OP_LOOKUP;
      else op = sst_pkg::OP_SET_MARK;
    end else if (pick < 30) op = sst_pkg::OP_INSERT;
    else if (pick < 42) op = sst_pkg::OP_TEXT_DELETE;
    else if (pick < 52) op = sst_pkg::OP_TEXT_INSERT;
    else if (pick < 80) op = sst_pkg::OP_LOOKUP;
    else if (pick < 84) op = sst_pkg::OP_CANCEL_MARK;
    else if (pick < 94) op = sst_pkg::OP_SET_MARK;
    else if (pick < 98) op = sst_pkg::OP_STATUS;
    else op = OP_UNUSED;
    pick = $urandom_range(0, 99);
    if (pick < 80) pos = POS_BITS'($urandom_range(0, 300));
    else if (pick < 90) pos = POS_BITS'($urandom_range(0, 65535));
    else pos = POS_BITS'($urandom_range(65500, 65535));
    pick = $urandom_range(0, 99);
    if (pick < 80) len = sst_pkg::LEN_IN_W'($urandom_range(0, 18));
    else if (pick < 95) len = sst_pkg::LEN_IN_W'($urandom_range(0, 64));
    else len = sst_pkg::LEN_IN_W'($urandom_range(0, 65535));
    send_word(op, pos, len, sst_pkg::CODE_W'($urandom_range(0, 65535)));
  endtask

  initial begin
    edit_if.valid       = 1'b0;
    edit_if.opcode      = sst_pkg::OP_STATUS;
    edit_if.position    = '0;
    edit_if.length      = '0;
    edit_if.symbol_code = '0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table, then edge values of every field.
    send_word(sst_pkg::OP_STATUS, 0, 0, 0);
    send_word(sst_pkg::OP_LOOKUP, 0, 0, 0);
    send_word(sst_pkg::OP_TEXT_DELETE, 0, 16'hFFFF, 0);
    send_word(sst_pkg::OP_TEXT_INSERT, 0, 16'hFFFF, 0);
    send_word(sst_pkg::OP_INSERT, 5, 0, 16'h0000);
    send_word(sst_pkg::OP_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(sst_pkg::OP_INSERT, 100, 5, 16'h1234);
    send_word(sst_pkg::OP_INSERT, 100, 3, 16'h5678);
    send_word(sst_pkg::OP_LOOKUP, 100, 0, 0);
    send_word(sst_pkg::OP_LOOKUP, 104, 0, 0);
    send_word(sst_pkg::OP_LOOKUP, 5, 0, 0);
    send_word(sst_pkg::OP_LOOKUP, 16'hFFFF, 0, 0);
    send_word(sst_pkg::OP_SET_MARK, 101, 0, 0);
    send_word(sst_pkg::OP_SET_MARK, 103, 1, 0);
    send_word(sst_pkg::OP_LOOKUP, 103, 0, 0);
    send_word(sst_pkg::OP_TEXT_INSERT, 65000, 40000, 0);
    send_word(sst_pkg::OP_TEXT_INSERT, 100, 0, 0);
    send_word(sst_pkg::OP_TEXT_DELETE, 5, 9, 0);
    send_word(sst_pkg::OP_LOOKUP, 91, 0, 0);
    send_word(sst_pkg::OP_CANCEL_MARK, 0, 0, 0);
    send_word(sst_pkg::OP_TEXT_DELETE, 92, 2, 0);
    send_word(OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(sst_pkg::OP_STATUS, 0, 0, 0);
    send_word(sst_pkg::OP_TEXT_DELETE, 0, 16'hFFFF, 0);
    send_word(sst_pkg::OP_LOOKUP, 0, 0, 0);

    for (int phase = 0; phase < PHASES; phase++) begin
      steady_flow = (phase % 4 == 3);
      if (phase == 2) hold_off_req = 1'b1;
      repeat (WORDS_PER_PHASE) send_random(phase % 3 == 1);
    end
    steady_flow = 1'b0;
    edit_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d edit words and checked %0d results.", words_sent, checked);
    $display("Lookups that hit a span: %0d, inserts refused on a full table: %0d.",
             hits, drops);
    if (mismatch_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/sst_pkg.sv
rtl/core/sst_in_if.sv
rtl/core/sst_out_if.sv
rtl/core/sst_cell.sv
rtl/core/sorted_span_table.sv
tb/span_table_checker.sv
tb/tb.sv
